// File: src/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg: shared types and constants for the curve lookup core
// Field widths, register map codes, reset values and parameter defaults.
// ----------------------------------------------------------------------------
package plc_pkg;

  // Port field widths
  localparam int FIELD_W    = 16;
  localparam int CNT_W      = 4;
  localparam int SLOT_W     = 16;
  localparam int WORD_W     = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;

  // Parameter defaults
  localparam int MAX_SAMPLES_DEF = 8;
  localparam int VALUE_BITS_DEF  = 16;

  // Reset values of the configuration registers
  localparam logic [FIELD_W-1:0] INPUT_MIN_RST    = 16'h0000;
  localparam logic [FIELD_W-1:0] INPUT_MAX_RST    = 16'h7FFF;
  localparam logic [CNT_W-1:0]   SAMPLE_COUNT_RST = 4'd1;

  // Register index, taken from paddr[5:3]
  typedef enum logic [2:0] {
    REG_INPUT_MIN    = 3'd0,
    REG_INPUT_MAX    = 3'd1,
    REG_SAMPLE_COUNT = 3'd2,
    REG_SAMPLES_LO   = 3'd3,
    REG_SAMPLES_HI   = 3'd4
  } plc_reg_t;

  // Bypass flags carried along with every beat
  typedef struct packed {
    logic invalid;
    logic single;
  } plc_flags_t;

endpackage

// File: src/plc_div_cell.sv
// ----------------------------------------------------------------------------
// plc_div_cell: one restoring division step
// Tries to subtract the divisor shifted by SHIFT and sets that quotient bit.
// ----------------------------------------------------------------------------
module plc_div_cell #(
  parameter int DW    = 16,
  parameter int QW    = 3,
  parameter int SHIFT = 0,
  parameter int SW    = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [DW-1:0]    divisor,
  input  logic             in_valid,
  input  logic [DW+QW-1:0] in_rem,
  input  logic [QW-1:0]    in_quo,
  input  logic [SW-1:0]    in_side,
  output logic             out_valid,
  output logic [DW+QW-1:0] out_rem,
  output logic [QW-1:0]    out_quo,
  output logic [SW-1:0]    out_side
);

  localparam int RW = DW + QW;

  logic          valid_r;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [SW-1:0] side_r;
  logic [RW:0]   trial;
  logic          fits;

  always_comb begin
    trial   = {1'b0, in_rem} - ((RW + 1)'(divisor) << SHIFT);
    fits    = ~trial[RW];
    rem_nxt = fits ? trial[RW-1:0] : in_rem;
    quo_nxt = in_quo;
    quo_nxt[SHIFT] = fits;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_quo   = quo_r;
  assign out_side  = side_r;

endmodule

// File: src/plc_div_chain.sv
// ----------------------------------------------------------------------------
// plc_div_chain: row of division cells, one quotient bit per cell
// Most significant quotient bit first; sideband rides along unchanged.
// ----------------------------------------------------------------------------
module plc_div_chain #(
  parameter int DW = 16,
  parameter int QW = 3,
  parameter int SW = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [DW-1:0]    divisor,
  input  logic             in_valid,
  input  logic [DW+QW-1:0] in_dividend,
  input  logic [SW-1:0]    in_side,
  output logic             out_valid,
  output logic [QW-1:0]    out_quotient,
  output logic [DW+QW-1:0] out_remainder,
  output logic [SW-1:0]    out_side
);

  localparam int RW = DW + QW;

  logic          v_w    [QW+1];
  logic [RW-1:0] r_w    [QW+1];
  logic [QW-1:0] q_w    [QW+1];
  logic [SW-1:0] s_w    [QW+1];

  assign v_w[0] = in_valid;
  assign r_w[0] = in_dividend;
  assign q_w[0] = '0;
  assign s_w[0] = in_side;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    plc_div_cell #(
      .DW    (DW),
      .QW    (QW),
      .SHIFT (QW - 1 - k),
      .SW    (SW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .divisor   (divisor),
      .in_valid  (v_w[k]),
      .in_rem    (r_w[k]),
      .in_quo    (q_w[k]),
      .in_side   (s_w[k]),
      .out_valid (v_w[k+1]),
      .out_rem   (r_w[k+1]),
      .out_quo   (q_w[k+1]),
      .out_side  (s_w[k+1])
    );
  end

  assign out_valid     = v_w[QW];
  assign out_quotient  = q_w[QW];
  assign out_remainder = r_w[QW];
  assign out_side      = s_w[QW];

endmodule

// File: src/piecewise_linear_curve_lookup_core.sv
// ----------------------------------------------------------------------------
// piecewise_linear_curve_lookup_core: piecewise linear curve lookup
// Maps each input value through a curve of evenly spaced samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on in_valid/in_value and are taken when in_stall is
//   low. Each beat yields exactly one result beat on out_valid/out_value/
//   out_config_invalid, in order, taken when out_stall is low.
//   Configuration (range ends, sample count, two words of packed samples) is
//   written over the APB-style port at byte address 8*index, 64-bit data,
//   only while no beat is in flight. pready is tied high; reads return the
//   stored register value.
// Timing:
//   One beat per cycle sustained while no stalled result is held. A beat
//   passes the front register, the restoring division cells for the
//   segment index (one bit per cell), the select and product registers,
//   the cells for the interpolation quotient (one bit per cell) and the output register.
// Stall:
//   The whole pipeline moves together; when a result sits in the output
//   register and out_stall is high, every stage holds and in_stall rises.
//   An empty output register never blocks the input.
// Reset:
//   rst_n (synchronous) empties the pipeline and restores register defaults:
//   range 0..32767, one sample, all samples zero.
// ----------------------------------------------------------------------------
module piecewise_linear_curve_lookup_core
  import plc_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FIELD_W-1:0]    in_value,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FIELD_W-1:0]    out_value,
  output logic                  out_config_invalid,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int VB  = VALUE_BITS;
  localparam int IW  = $clog2(MAX_SAMPLES);
  localparam int SW1 = $bits(plc_flags_t);
  localparam int SW2 = 1 + VB + SW1;
  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_SAMPLES);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [FIELD_W-1:0] input_min_r;
  logic [FIELD_W-1:0] input_max_r;
  logic [CNT_W-1:0]   sample_count_r;
  logic [WORD_W-1:0]  samples_lo_r;
  logic [WORD_W-1:0]  samples_hi_r;
  plc_reg_t           reg_sel;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = plc_reg_t'(paddr[5:3]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_min_r    <= INPUT_MIN_RST;
      input_max_r    <= INPUT_MAX_RST;
      sample_count_r <= SAMPLE_COUNT_RST;
      samples_lo_r   <= '0;
      samples_hi_r   <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_INPUT_MIN:    input_min_r    <= pwdata[FIELD_W-1:0];
        REG_INPUT_MAX:    input_max_r    <= pwdata[FIELD_W-1:0];
        REG_SAMPLE_COUNT: sample_count_r <= pwdata[CNT_W-1:0];
        REG_SAMPLES_LO:   samples_lo_r   <= pwdata;
        REG_SAMPLES_HI:   samples_hi_r   <= pwdata;
        default: ; // drop writes past the register list
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_INPUT_MIN:    prdata = CFG_DATA_W'(input_min_r);
      REG_INPUT_MAX:    prdata = CFG_DATA_W'(input_max_r);
      REG_SAMPLE_COUNT: prdata = CFG_DATA_W'(sample_count_r);
      REG_SAMPLES_LO:   prdata = samples_lo_r;
      REG_SAMPLES_HI:   prdata = samples_hi_r;
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Derived configuration. The user must change config only with the
  // pipeline empty; the block does not enforce it. Every stage reads these live.
  // --------------------------------------------------------------------------
  logic signed [VB-1:0] lo, hi;
  logic signed [VB:0]   rng_full;
  logic [VB-1:0]        rng;
  logic [CNT_W-1:0]     n_sel, segs_full;
  logic [IW-1:0]        segs;
  plc_flags_t           flags_now;
  logic signed [VB-1:0] smp [MAX_SAMPLES];

  for (genvar k = 0; k < MAX_SAMPLES; k++) begin : g_smp
    localparam int LSB = (k % 4) * SLOT_W;
    if (k < 4) begin : g_lo
      assign smp[k] = samples_lo_r[LSB +: VB];
    end else begin : g_hi
      assign smp[k] = samples_hi_r[LSB +: VB];
    end
  end

  always_comb begin
    lo       = input_min_r[VB-1:0];
    hi       = input_max_r[VB-1:0];
    rng_full = (VB + 1)'(hi) - (VB + 1)'(lo);
    rng      = rng_full[VB-1:0];
    // zero counts as one sample, counts past the table saturate
    if (sample_count_r == '0) begin
      n_sel = CNT_W'(1);
    end else if (sample_count_r > MAX_N) begin
      n_sel = MAX_N;
    end else begin
      n_sel = sample_count_r;
    end
    segs_full         = n_sel - CNT_W'(1);
    segs              = segs_full[IW-1:0];
    flags_now.invalid = (hi <= lo);
    flags_now.single  = (n_sel == CNT_W'(1));
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: every stage moves unless a result is held at the output
  // --------------------------------------------------------------------------
  logic adv;
  logic out_valid_r;

  assign adv      = ~out_valid_r | ~out_stall;
  assign in_stall = ~adv;

  // --------------------------------------------------------------------------
  // Front stage: clamp, offset from the range start, scale by segment count
  // --------------------------------------------------------------------------
  logic signed [VB-1:0] v_in, v_clamp;
  logic signed [VB:0]   off_full;
  logic [VB+IW-1:0]     scaled_nxt, scaled_r;
  logic                 fr_valid_r;
  plc_flags_t           fr_flags_r;

  always_comb begin
    v_in    = in_value[VB-1:0];
    v_clamp = v_in;
    if (v_in < lo) begin
      v_clamp = lo;
    end
    if (v_in > hi) begin
      v_clamp = hi;
    end
    off_full   = (VB + 1)'(v_clamp) - (VB + 1)'(lo);
    scaled_nxt = (VB + IW)'(off_full[VB-1:0]) * (VB + IW)'(segs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (adv) begin
      fr_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      scaled_r   <= scaled_nxt;
      fr_flags_r <= flags_now;
    end
  end

  // --------------------------------------------------------------------------
  // Segment index and remainder: scaled / range, one bit per cell
  // --------------------------------------------------------------------------
  logic             d1_valid;
  logic [IW-1:0]    d1_quo;
  logic [VB+IW-1:0] d1_rem;
  logic [SW1-1:0]   d1_side;

  plc_div_chain #(
    .DW (VB),
    .QW (IW),
    .SW (SW1)
  ) u_idx_div (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (adv),
    .divisor       (rng),
    .in_valid      (fr_valid_r),
    .in_dividend   (scaled_r),
    .in_side       (fr_flags_r),
    .out_valid     (d1_valid),
    .out_quotient  (d1_quo),
    .out_remainder (d1_rem),
    .out_side      (d1_side)
  );

  // --------------------------------------------------------------------------
  // Segment select: limit the index to the last segment (input at maximum
  // then lands exactly on the last sample), fetch both end samples
  // --------------------------------------------------------------------------
  logic [IW-1:0]        idx, idx_p1;
  logic [VB-1:0]        seg_rem;
  logic signed [VB-1:0] left, right;
  logic signed [VB:0]   diff, diff_abs;

  logic                 fx_valid_r;
  logic [VB-1:0]        fx_mag_r, fx_rem_r;
  logic                 fx_neg_r;
  logic signed [VB-1:0] fx_left_r;
  plc_flags_t           fx_flags_r;

  always_comb begin
    if (d1_quo >= segs) begin
      idx     = segs - IW'(1);
      seg_rem = rng;
    end else begin
      idx     = d1_quo;
      seg_rem = d1_rem[VB-1:0];
    end
    idx_p1   = idx + IW'(1);
    left     = smp[idx];
    right    = smp[idx_p1];
    diff     = (VB + 1)'(right) - (VB + 1)'(left);
    diff_abs = diff[VB] ? -diff : diff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_valid_r <= 1'b0;
    end else if (adv) begin
      fx_valid_r <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fx_mag_r   <= diff_abs[VB-1:0];
      fx_neg_r   <= diff[VB];
      fx_rem_r   <= seg_rem;
      fx_left_r  <= left;
      fx_flags_r <= d1_side;
    end
  end

  // --------------------------------------------------------------------------
  // Product of the sample step magnitude and the position in the segment
  // --------------------------------------------------------------------------
  logic                 ml_valid_r;
  logic [2*VB-1:0]      ml_prod_r;
  logic [SW2-1:0]       ml_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ml_valid_r <= 1'b0;
    end else if (adv) begin
      ml_valid_r <= fx_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ml_prod_r <= (2 * VB)'(fx_mag_r) * (2 * VB)'(fx_rem_r);
      ml_side_r <= {fx_neg_r, fx_left_r, fx_flags_r};
    end
  end

  // --------------------------------------------------------------------------
  // Interpolation quotient: |step * position| / range, one bit per cell
  // --------------------------------------------------------------------------
  logic            d2_valid;
  logic [VB-1:0]   d2_quo;
  logic [2*VB-1:0] d2_rem;
  logic [SW2-1:0]  d2_side;

  plc_div_chain #(
    .DW (VB),
    .QW (VB),
    .SW (SW2)
  ) u_frac_div (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (adv),
    .divisor       (rng),
    .in_valid      (ml_valid_r),
    .in_dividend   (ml_prod_r),
    .in_side       (ml_side_r),
    .out_valid     (d2_valid),
    .out_quotient  (d2_quo),
    .out_remainder (d2_rem),
    .out_side      (d2_side)
  );

  // --------------------------------------------------------------------------
  // Output stage: floor for falling segments, add left sample, bypass cases
  // --------------------------------------------------------------------------
  logic                 o_neg;
  logic signed [VB-1:0] o_left;
  plc_flags_t           o_flags;
  logic signed [VB+1:0] q_ext, q_floor, res_full;
  logic signed [VB-1:0] res;
  logic [FIELD_W-1:0]   out_value_r, out_value_nxt;
  logic                 out_invalid_r;

  always_comb begin
    {o_neg, o_left, o_flags} = d2_side;
    q_ext = (VB + 2)'(d2_quo);
    // negative step: floor rounds away from zero when anything is left over
    if (o_neg) begin
      q_floor = -(q_ext + (VB + 2)'(|d2_rem));
    end else begin
      q_floor = q_ext;
    end
    res_full = (VB + 2)'(o_left) + q_floor;
    res      = res_full[VB-1:0];
    if (o_flags.invalid) begin
      out_value_nxt = '0;
    end else if (o_flags.single) begin
      out_value_nxt = FIELD_W'(smp[0]);
    end else begin
      out_value_nxt = FIELD_W'(res);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_value_r   <= out_value_nxt;
      out_invalid_r <= o_flags.invalid;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_value          = out_value_r;
  assign out_config_invalid = out_invalid_r;

endmodule

// File: src/plc_checker.sv
// ----------------------------------------------------------------------------
// plc_checker: port-level checks for the curve lookup core
// Watches the two channels and is bound to the top level.
// ----------------------------------------------------------------------------
module plc_checker
  import plc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [FIELD_W-1:0] out_value,
  input logic               out_config_invalid
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value)
      && $stable(out_config_invalid))
    else $error("result beat changed while stalled");

  // Input stalls exactly when a held result blocks the pipeline
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  // An invalid range always reads as zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_config_invalid |-> out_value == '0)
    else $error("nonzero value on invalid configuration");

endmodule

bind piecewise_linear_curve_lookup_core plc_checker u_plc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_value          (out_value),
  .out_config_invalid (out_config_invalid)
);

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the piecewise linear curve lookup core
// Writes range, sample count and sample words over the register port, then
// streams input beats with random idling on both channels. Every accepted
// input beat is scored against an integer model of the curve, and every
// result beat is compared in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import plc_pkg::*;

  // Cycles with no beat and no register access before the run is abandoned.
  // Covers pipeline latency, the longest sender gap and receiver stall and a
  // full burst of register writes, with plenty of margin.
  localparam int HANG_LIMIT = 2000;
  // Cycles to keep watching the result channel after the last result.
  localparam int TAIL_CYCLES = 40;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_BEATS = 71;
  localparam int NUM_REGS = 8;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic               invalid;
  } curve_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [FIELD_W-1:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [FIELD_W-1:0] out_value;
  logic               out_config_invalid;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Shadow copy of the configuration registers, updated on each write
  logic [FIELD_W-1:0] range_lo = INPUT_MIN_RST;
  logic [FIELD_W-1:0] range_hi = INPUT_MAX_RST;
  logic [CNT_W-1:0]   curve_points = SAMPLE_COUNT_RST;
  logic [WORD_W-1:0]  points_lo_word = '0;
  logic [WORD_W-1:0]  points_hi_word = '0;

  logic [FIELD_W-1:0] value_queue[$];
  curve_result_t      curve_expect[$];

  logic in_taken = 1'b0;
  bit   idle_on = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  int   mismatches = 0;

  piecewise_linear_curve_lookup_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_value          (out_value),
    .out_config_invalid (out_config_invalid),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Signed sample k of the curve, taken from the packed sample words
  function automatic longint curve_point(input int k);
    logic [WORD_W-1:0] word;
    word = (k < 4) ? points_lo_word : points_hi_word;
    return longint'($signed(word[(k % 4) * SLOT_W +: SLOT_W]));
  endfunction

  // Interpolated curve value for one input under the current registers
  function automatic curve_result_t interpolate(input logic [FIELD_W-1:0] x);
    curve_result_t res;
    longint lo, hi, v, n, span, segs, scaled, seg, frac, left, right, num, q;
    lo = longint'($signed(range_lo));
    hi = longint'($signed(range_hi));
    v = longint'($signed(x));
    n = longint'(curve_points);
    res.invalid = 1'b0;
    if (hi <= lo) begin
      res.value = '0;
      res.invalid = 1'b1;
      return res;
    end
    // An empty curve acts as one sample; oversize counts saturate
    if (n == 0) n = 1;
    if (n > MAX_SAMPLES_DEF) n = MAX_SAMPLES_DEF;
    if (n == 1) begin
      res.value = FIELD_W'(curve_point(0));
      return res;
    end
    span = hi - lo;
    segs = n - 1;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    scaled = (v - lo) * segs;
    seg = scaled / span;
    frac = scaled % span;
    // Input at the top of the range lands on the end of the last segment
    if (seg >= segs) begin
      seg = segs - 1;
      frac = span;
    end
    left = curve_point(int'(seg));
    right = curve_point(int'(seg) + 1);
    num = (right - left) * frac;
    q = num / span;
    if ((num % span) < 0) q = q - 1;
    res.value = FIELD_W'(left + q);
    return res;
  endfunction

  // Idle length: mostly none, often short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Input value aimed at the interesting spots of the current range
  function automatic logic [FIELD_W-1:0] aim_value();
    int lo, hi;
    lo = $signed(range_lo);
    hi = $signed(range_hi);
    case ($urandom_range(0, 7))
      0, 1: return FIELD_W'($urandom);
      2: return range_lo;
      3: return range_hi;
      4: return FIELD_W'(lo - $urandom_range(1, 4));
      5: return FIELD_W'(hi + $urandom_range(0, 4));
      default: begin
        if (hi > lo) return FIELD_W'(lo + int'($urandom_range(0, hi - lo)));
        return FIELD_W'($urandom);
      end
    endcase
  endfunction

  // Packed sample word: each slot an extreme or a random value
  function automatic logic [WORD_W-1:0] points_word();
    logic [WORD_W-1:0] w;
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(0, 3))
        0: w[k * SLOT_W +: SLOT_W] = 16'h8000;
        1: w[k * SLOT_W +: SLOT_W] = 16'h7FFF;
        default: w[k * SLOT_W +: SLOT_W] = SLOT_W'($urandom);
      endcase
    end
    return w;
  endfunction

  // Register write: setup cycle, then access cycle until pready
  task automatic cfg_write(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 3'b000};
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_INPUT_MIN:    range_lo = data[FIELD_W-1:0];
      REG_INPUT_MAX:    range_hi = data[FIELD_W-1:0];
      REG_SAMPLE_COUNT: curve_points = data[CNT_W-1:0];
      REG_SAMPLES_LO:   points_lo_word = data;
      REG_SAMPLES_HI:   points_hi_word = data;
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic cfg_all(input int lo, input int hi, input int cnt,
                         input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1);
    cfg_write(REG_INPUT_MIN, CFG_DATA_W'(FIELD_W'(lo)));
    cfg_write(REG_INPUT_MAX, CFG_DATA_W'(FIELD_W'(hi)));
    cfg_write(REG_SAMPLE_COUNT, CFG_DATA_W'(CNT_W'(cnt)));
    cfg_write(REG_SAMPLES_LO, w0);
    cfg_write(REG_SAMPLES_HI, w1);
  endtask

  // Hold until every queued beat is sent and every result is back
  task automatic drain();
    while (!(value_queue.size() == 0 && !in_valid && curve_expect.size() == 0))
      @(posedge clk);
  endtask

  task automatic queue_values(input int count);
    for (int i = 0; i < count; i++) value_queue.push_back(aim_value());
  endtask

  // Driver: advance to the next beat once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (value_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_value <= value_queue.pop_front();
        send_gap <= idle_on ? idle_len() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: hold off results in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= idle_on ? idle_len() : 0;
    end
  end

  // Monitor: predict on each input beat, score each result beat, and
  // watch for a stuck pipeline
  always @(posedge clk) begin
    curve_result_t want;
    bit busy;
    busy = psel;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      curve_expect.push_back(interpolate(in_value));
      busy = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      busy = 1'b1;
      if (curve_expect.size() == 0) begin
        $error("unexpected result beat: out_value=%h out_config_invalid=%b",
               out_value, out_config_invalid);
        mismatches++;
      end else begin
        want = curve_expect.pop_front();
        if (out_value !== want.value) begin
          $error("out_value: expected %h, got %h", want.value, out_value);
          mismatches++;
        end
        if (out_config_invalid !== want.invalid) begin
          $error("out_config_invalid: expected %b, got %b", want.invalid,
                 out_config_invalid);
          mismatches++;
        end
      end
    end
    quiet_cycles = busy ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int lo, hi, a, b, cnt;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset defaults: a single zero sample over 0..32767
    value_queue.push_back(16'h8000); value_queue.push_back(16'h7FFF);
    value_queue.push_back(16'h0000); value_queue.push_back(16'hFFFF);
    drain();

    // Full range, eight samples swinging between the extremes
    cfg_all(-32768, 32767, 8, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000},
            {16'h7FFF, 16'hFFFF, 16'h0001, 16'h8000});
    value_queue.push_back(16'h8000); value_queue.push_back(16'h7FFF);
    value_queue.push_back(16'h0000); value_queue.push_back(16'hFFFF);
    value_queue.push_back(16'h0001); value_queue.push_back(16'h7FFE);
    drain();

    // Narrow range: clamp below and above, hit both ends exactly
    cfg_all(-100, 100, 4, {16'h0123, 16'h8000, 16'h7FFF, 16'hFF00}, '0);
    value_queue.push_back(16'h8000); value_queue.push_back(16'h7FFF);
    value_queue.push_back(16'hFF9C); value_queue.push_back(16'h0064);
    value_queue.push_back(16'h0000);
    drain();

    // Invalid range: equal ends, then ends swapped
    cfg_write(REG_INPUT_MAX, CFG_DATA_W'(FIELD_W'(-100)));
    value_queue.push_back(16'h0000); value_queue.push_back(16'hFF9C);
    drain();
    cfg_write(REG_INPUT_MAX, CFG_DATA_W'(FIELD_W'(-32768)));
    value_queue.push_back(16'h7FFF);
    drain();

    // Zero sample count acts as one; oversize count saturates
    cfg_write(REG_INPUT_MAX, CFG_DATA_W'(FIELD_W'(32767)));
    cfg_write(REG_SAMPLE_COUNT, '0);
    value_queue.push_back(16'h1234); value_queue.push_back(16'h7FFF);
    drain();
    cfg_write(REG_SAMPLE_COUNT, CFG_DATA_W'(4'hF));
    value_queue.push_back(16'h7FFF); value_queue.push_back(16'h3000);
    drain();

    // Writes past the register map must leave the curve alone
    for (int i = REG_SAMPLES_HI + 1; i < NUM_REGS; i++)
      cfg_write(3'(i), {$urandom, $urandom});
    value_queue.push_back(16'h4000); value_queue.push_back(16'hC000);
    drain();

    // Random phases: new registers each time, idling off every fourth phase
    for (int p = 0; p < RAND_PHASES; p++) begin
      a = int'($urandom_range(0, 65535)) - 32768;
      b = int'($urandom_range(0, 65535)) - 32768;
      case ($urandom_range(0, 9))
        0: begin lo = -32768; hi = 32767; end
        1: begin lo = a; hi = a; end
        2: begin lo = (a > b) ? a : b; hi = (a > b) ? b : a; end
        3, 4: begin
          lo = int'($urandom_range(0, 65400)) - 32768;
          hi = lo + int'($urandom_range(1, 20));
        end
        default: begin
          lo = (a < b) ? a : b;
          hi = (a < b) ? b : a;
          if (hi == lo) hi = lo + 1;
        end
      endcase
      if (p == 0) cnt = 8;
      else if (p == 1) cnt = 2;
      else if ($urandom_range(0, 9) < 7) cnt = $urandom_range(2, 8);
      else cnt = $urandom_range(0, 15);
      cfg_all(lo, hi, cnt, points_word(), points_word());
      idle_on = (p % 4) != 3;
      if (p == 5) begin
        // Pause the sender mid-phase until the pipeline is empty
        queue_values(PHASE_BEATS / 2);
        drain();
        queue_values(PHASE_BEATS - PHASE_BEATS / 2);
      end else begin
        queue_values(PHASE_BEATS);
      end
      drain();
    end

    idle_on = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
src/plc_pkg.sv
src/plc_div_cell.sv
src/plc_div_chain.sv
src/piecewise_linear_curve_lookup_core.sv
src/plc_checker.sv
bench/tb_top.sv
